// ----- sv/v3cdfr_pkg.sv -----
package v3cdfr_pkg;

   // Parser phases of the byte walk.
   typedef enum logic [2:0] {
      PH_FILE_HDR,
      PH_UNIT_SIZE,
      PH_UNIT_HDR,
      PH_NAL_PREC,
      PH_NAL_SIZE,
      PH_NAL_BODY,
      PH_SKIP,
      PH_WAIT
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NAL,
      KIND_PSET,
      KIND_BAD_UNIT,
      KIND_BAD_NAL
   } record_kind_type;

   // V3C unit types the walk cares about.
   localparam logic [4:0] UT_VPS = 5'd0;
   localparam logic [4:0] UT_AD  = 5'd1;
   localparam logic [4:0] UT_GVD = 5'd3;
   localparam logic [4:0] UT_AVD = 5'd4;
   localparam logic [4:0] UT_PVD = 5'd5;
   localparam logic [4:0] UT_CAD = 5'd6;

   localparam int unsigned HDR_BYTES = 4;

   typedef struct packed {
      record_kind_type record_kind;
      logic [4:0]      unit_type;
      logic [31:0]     payload_offset;
      logic [31:0]     payload_size;
      logic [3:0]      pset_num;
      logic [5:0]      atlas_num;
      logic [3:0]      map_num;
      logic            aux_flag;
      logic [6:0]      attribute_index;
      logic [4:0]      partition_index;
   } record_type;

endpackage

// ----- sv/v3cdfr_if.sv -----
interface v3cdfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       last_byte;

   modport source (output valid, output byte_value, output last_byte, input ready);
   modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

interface v3cdfr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  record_kind;
   logic [4:0]  unit_type;
   logic [31:0] payload_offset;
   logic [31:0] payload_size;
   logic [3:0]  pset_num;
   logic [5:0]  atlas_num;
   logic [3:0]  map_num;
   logic        aux_flag;
   logic [6:0]  attribute_index;
   logic [4:0]  partition_index;

   modport source (
      output valid, output record_kind, output unit_type, output payload_offset,
      output payload_size, output pset_num, output atlas_num, output map_num,
      output aux_flag, output attribute_index, output partition_index,
      input ready
   );
   modport sink (
      input valid, input record_kind, input unit_type, input payload_offset,
      input payload_size, input pset_num, input atlas_num, input map_num,
      input aux_flag, input attribute_index, input partition_index,
      output ready
   );
endinterface

// ----- sv/v3cdfr_parse_core.sv -----
module v3cdfr_parse_core
   import v3cdfr_pkg::*;
#(
   parameter int OFFSET_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] byte_value,
   input  logic       last_byte,
   output logic       rec_valid,
   output record_type rec
);

   phase_type                phase_ff, phase_in;
   logic [1:0]               usp_ff, usp_in;
   logic [2:0]               nsp_ff, nsp_in;
   logic [2:0]               fcount_ff, fcount_in;
   logic [31:0]              acc_ff, acc_in;
   logic [23:0]              unit_left_ff, unit_left_in;
   logic [31:0]              nal_left_ff, nal_left_in;
   logic [31:0]              hdr_ff, hdr_in;
   logic [OFFSET_BITS-1:0]   offset_ff, offset_in;

   logic [31:0]              acc_shift;
   logic [31:0]              hdr_shift;
   logic [2:0]               cnt_inc;
   logic [23:0]              unit_dec;
   logic [31:0]              nal_dec;
   logic [OFFSET_BITS-1:0]   offset_inc;
   logic [OFFSET_BITS+31:0]  here_wide;
   logic [OFFSET_BITS+31:0]  next_wide;
   logic                     unit_prec_ok;
   logic                     nal_prec_ok;
   logic                     in_unit;
   record_type               hd;

   assign acc_shift    = {acc_ff[23:0], byte_value};
   assign hdr_shift    = {hdr_ff[23:0], byte_value};
   assign cnt_inc      = fcount_ff + 3'd1;
   assign unit_dec     = unit_left_ff - 24'd1;
   assign nal_dec      = nal_left_ff - 32'd1;
   assign offset_inc   = offset_ff + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
   assign here_wide    = {32'd0, offset_ff};
   assign next_wide    = {32'd0, offset_inc};
   assign unit_prec_ok = (byte_value[7:5] == 3'd1) || (byte_value[7:5] == 3'd2);
   assign nal_prec_ok  = (byte_value[7:5] != 3'd0) && (byte_value[7:5] <= 3'd3);

   // Header field decode from the held four header bytes.
   always_comb begin
      hd           = '0;
      hd.unit_type = hdr_ff[31:27];
      if (hd.unit_type >= UT_AD && hd.unit_type <= UT_CAD) begin
         hd.pset_num = {hdr_ff[26:24], hdr_ff[23]};
      end
      if (hd.unit_type >= UT_AD && hd.unit_type <= UT_PVD) begin
         hd.atlas_num = hdr_ff[22:17];
      end
      if (hd.unit_type == UT_GVD) begin
         hd.map_num  = {hdr_ff[16], hdr_ff[15:13]};
         hd.aux_flag = hdr_ff[12];
      end else if (hd.unit_type == UT_AVD) begin
         hd.attribute_index = {hdr_ff[16], hdr_ff[15:10]};
         hd.partition_index = {hdr_ff[9:8], hdr_ff[7:5]};
         hd.map_num         = hdr_ff[4:1];
         hd.aux_flag        = hdr_ff[0];
      end
   end

   // Next state.
   always_comb begin
      phase_in     = phase_ff;
      usp_in       = usp_ff;
      nsp_in       = nsp_ff;
      fcount_in    = fcount_ff;
      acc_in       = acc_ff;
      unit_left_in = unit_left_ff;
      nal_left_in  = nal_left_ff;
      hdr_in       = hdr_ff;
      offset_in    = offset_ff;
      in_unit      = 1'b0;
      if (step) begin
         case (phase_ff)
            PH_FILE_HDR: begin
               if (unit_prec_ok) begin
                  usp_in    = byte_value[6:5] + 2'd1;
                  phase_in  = PH_UNIT_SIZE;
                  fcount_in = '0;
                  acc_in    = '0;
               end else if (!last_byte) begin
                  phase_in = PH_WAIT;
               end
            end
            PH_UNIT_SIZE: begin
               acc_in    = acc_shift;
               fcount_in = cnt_inc;
               if (cnt_inc >= {1'b0, usp_ff}) begin
                  unit_left_in = acc_shift[23:0];
                  fcount_in    = '0;
                  acc_in       = '0;
                  if (acc_shift[23:0] != 24'd0) begin
                     phase_in = PH_UNIT_HDR;
                     hdr_in   = '0;
                  end
               end
            end
            PH_UNIT_HDR: begin
               in_unit      = 1'b1;
               hdr_in       = hdr_shift;
               fcount_in    = cnt_inc;
               unit_left_in = unit_dec;
               if (cnt_inc == 3'd1 && byte_value[7:3] == UT_VPS) begin
                  fcount_in = '0;
                  phase_in  = PH_SKIP;
               end else if (cnt_inc >= 3'(HDR_BYTES)) begin
                  fcount_in = '0;
                  acc_in    = '0;
                  if (hdr_shift[31:27] == UT_AD || hdr_shift[31:27] == UT_CAD) begin
                     phase_in = PH_NAL_PREC;
                  end else begin
                     nsp_in   = 3'(HDR_BYTES);
                     phase_in = PH_NAL_SIZE;
                  end
               end
            end
            PH_NAL_PREC: begin
               in_unit      = 1'b1;
               unit_left_in = unit_dec;
               if (nal_prec_ok) begin
                  nsp_in   = byte_value[7:5] + 3'd1;
                  phase_in = PH_NAL_SIZE;
               end else if (unit_dec != 24'd0) begin
                  phase_in = PH_WAIT;
                  in_unit  = 1'b0;
               end
            end
            PH_NAL_SIZE: begin
               in_unit      = 1'b1;
               unit_left_in = unit_dec;
               acc_in       = acc_shift;
               fcount_in    = cnt_inc;
               if (cnt_inc >= nsp_ff) begin
                  nal_left_in = acc_shift;
                  fcount_in   = '0;
                  acc_in      = '0;
                  if (acc_shift != 32'd0) begin
                     phase_in = PH_NAL_BODY;
                  end
               end
            end
            PH_NAL_BODY: begin
               in_unit      = 1'b1;
               unit_left_in = unit_dec;
               nal_left_in  = nal_dec;
               if (nal_dec == 32'd0) begin
                  phase_in = PH_NAL_SIZE;
               end
            end
            PH_SKIP: begin
               in_unit      = 1'b1;
               unit_left_in = unit_dec;
            end
            default: begin
            end
         endcase

         // Unit end returns the walk to the next unit size field.
         if (in_unit && unit_left_in == 24'd0) begin
            phase_in  = PH_UNIT_SIZE;
            fcount_in = '0;
            acc_in    = '0;
         end

         offset_in = offset_inc;

         if (last_byte) begin
            phase_in     = PH_FILE_HDR;
            usp_in       = '0;
            nsp_in       = '0;
            fcount_in    = '0;
            acc_in       = '0;
            unit_left_in = '0;
            nal_left_in  = '0;
            hdr_in       = '0;
            offset_in    = '0;
         end
      end
   end

   // Record output.
   always_comb begin
      rec_valid = 1'b0;
      rec       = '0;
      case (phase_ff)
         PH_FILE_HDR: begin
            if (!unit_prec_ok && !last_byte) begin
               rec_valid          = 1'b1;
               rec.record_kind    = KIND_BAD_UNIT;
               rec.payload_offset = here_wide[31:0];
            end
         end
         PH_UNIT_HDR: begin
            if (cnt_inc == 3'd1 && byte_value[7:3] == UT_VPS) begin
               rec_valid          = 1'b1;
               rec.record_kind    = KIND_PSET;
               rec.payload_offset = here_wide[31:0];
               rec.payload_size   = {8'd0, unit_left_ff};
            end
         end
         PH_NAL_PREC: begin
            if (!nal_prec_ok && unit_dec != 24'd0) begin
               rec_valid          = 1'b1;
               rec                = hd;
               rec.record_kind    = KIND_BAD_NAL;
               rec.payload_offset = here_wide[31:0];
               rec.payload_size   = '0;
            end
         end
         PH_NAL_SIZE: begin
            if (cnt_inc >= nsp_ff) begin
               rec_valid          = 1'b1;
               rec                = hd;
               rec.record_kind    = KIND_NAL;
               rec.payload_offset = next_wide[31:0];
               rec.payload_size   = acc_shift;
            end
         end
         default: begin
         end
      endcase
      rec_valid = rec_valid && step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FILE_HDR;
         usp_ff       <= '0;
         nsp_ff       <= '0;
         fcount_ff    <= '0;
         acc_ff       <= '0;
         unit_left_ff <= '0;
         nal_left_ff  <= '0;
         hdr_ff       <= '0;
         offset_ff    <= '0;
      end else begin
         phase_ff     <= phase_in;
         usp_ff       <= usp_in;
         nsp_ff       <= nsp_in;
         fcount_ff    <= fcount_in;
         acc_ff       <= acc_in;
         unit_left_ff <= unit_left_in;
         nal_left_ff  <= nal_left_in;
         hdr_ff       <= hdr_in;
         offset_ff    <= offset_in;
      end
   end

endmodule

// ----- sv/v3c_sample_stream_deframer.sv -----
// V3C sample stream deframer.
//
// req carries the file one byte per transfer (byte_value) with last_byte
// marking the final byte of a file. rsp carries one record per NAL unit,
// per parameter-set unit, or per bad size-precision byte. Most bytes give
// no record.
//
// Timing: a byte transfer lands in the input register; the parser then runs
// on the held byte and loads its record into the record register once that
// register is free, and the record is valid on rsp from there. One byte per
// cycle sustained while rsp is ready; the parse state update on the
// registered byte sets that figure.
//
// Stall: while a record waits on rsp, hold every byte in the input register,
// whether it gives a record or not. An empty input register still takes one
// more byte; then req drops ready until the waiting record is taken.
//
// Reset clears both registers and the parse state: the block then expects
// a file header byte at offset 0. A byte with last_byte resets the parse state alike.
module v3c_sample_stream_deframer
   import v3cdfr_pkg::*;
#(
   parameter int OFFSET_BITS = 32
) (
   input logic          clock,
   input logic          reset,
   v3cdfr_req_if.sink   req,
   v3cdfr_rsp_if.source rsp
);

   // Input register.
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;

   // Record register.
   logic       rsp_valid_ff, rsp_valid_in;
   record_type rsp_rec_ff;

   logic       out_free;
   logic       step;
   logic       req_accept;
   logic       rec_valid;
   record_type rec;

   // Record register can load when empty or being drained this cycle.
   assign out_free   = !rsp_valid_ff || rsp.ready;
   // Parse the held byte only when its possible record has a place to go.
   assign step       = s1_valid_ff && out_free;
   assign req.ready  = !s1_valid_ff || out_free;
   assign req_accept = req.valid && req.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (step) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = rec_valid;
      end
   end

   v3cdfr_parse_core #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .byte_value (s1_byte_ff),
      .last_byte  (s1_last_ff),
      .rec_valid  (rec_valid),
      .rec        (rec)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: load on transfer, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff <= req.byte_value;
         s1_last_ff <= req.last_byte;
      end
      if (out_free && rec_valid) begin
         rsp_rec_ff <= rec;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.record_kind     = rsp_rec_ff.record_kind;
   assign rsp.unit_type       = rsp_rec_ff.unit_type;
   assign rsp.payload_offset  = rsp_rec_ff.payload_offset;
   assign rsp.payload_size    = rsp_rec_ff.payload_size;
   assign rsp.pset_num        = rsp_rec_ff.pset_num;
   assign rsp.atlas_num       = rsp_rec_ff.atlas_num;
   assign rsp.map_num         = rsp_rec_ff.map_num;
   assign rsp.aux_flag        = rsp_rec_ff.aux_flag;
   assign rsp.attribute_index = rsp_rec_ff.attribute_index;
   assign rsp.partition_index = rsp_rec_ff.partition_index;

endmodule

// ----- sv/v3cdfr_checker.sv -----
module v3cdfr_checker
   import v3cdfr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_record_kind,
   input logic [4:0]  rsp_unit_type,
   input logic [31:0] rsp_payload_offset,
   input logic [31:0] rsp_payload_size,
   input logic [3:0]  rsp_pset_num,
   input logic [5:0]  rsp_atlas_num,
   input logic [3:0]  rsp_map_num,
   input logic        rsp_aux_flag,
   input logic [6:0]  rsp_attribute_index,
   input logic [4:0]  rsp_partition_index
);

   logic all_ids_zero;

   assign all_ids_zero = rsp_unit_type == '0 && rsp_pset_num == '0
                         && rsp_atlas_num == '0 && rsp_map_num == '0
                         && !rsp_aux_flag && rsp_attribute_index == '0
                         && rsp_partition_index == '0;

   // Nothing leaves the block right after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("record valid right after reset");

   // A fresh record follows an earlier byte transfer.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("record without matching byte transfer");

   // A stalled record holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_record_kind)
         && $stable(rsp_payload_offset) && $stable(rsp_payload_size))
      else $error("stalled record changed");

   // Bad unit precision and parameter-set records carry no decoded header.
   a_plain_kinds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_record_kind == KIND_BAD_UNIT || rsp_record_kind == KIND_PSET)
         |-> all_ids_zero)
      else $error("header fields set on plain record");

   // Error records carry no size.
   a_error_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_record_kind == KIND_BAD_UNIT || rsp_record_kind == KIND_BAD_NAL)
         |-> rsp_payload_size == '0)
      else $error("error record with nonzero size");

endmodule

bind v3c_sample_stream_deframer v3cdfr_checker u_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req.valid),
   .req_ready           (req.ready),
   .rsp_valid           (rsp.valid),
   .rsp_ready           (rsp.ready),
   .rsp_record_kind     (rsp.record_kind),
   .rsp_unit_type       (rsp.unit_type),
   .rsp_payload_offset  (rsp.payload_offset),
   .rsp_payload_size    (rsp.payload_size),
   .rsp_pset_num        (rsp.pset_num),
   .rsp_atlas_num       (rsp.atlas_num),
   .rsp_map_num         (rsp.map_num),
   .rsp_aux_flag        (rsp.aux_flag),
   .rsp_attribute_index (rsp.attribute_index),
   .rsp_partition_index (rsp.partition_index)
);
